### rtl/cttf_pkg.sv
// ----------------------------------------------------------------------------
// cttf_pkg: shared types and constants of the time-to-full estimator
// Holds the queue item, the table entry layout, the divider status bundle,
// item kinds, register indexes and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cttf_pkg;

  // Kinds of queued items.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EST   = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // Configuration register indexes.
  localparam logic [3:0] REG_DESIGN_CAPACITY = 4'd0;
  localparam logic [3:0] REG_TABLE_LENGTH    = 4'd1;

  // Arithmetic constants. 3600 / 1000 reduces to 18 / 5.
  localparam int CC_SCALE_NUM = 18;
  localparam int MINUTE       = 60;
  localparam int LEVEL_SCALE  = 10;
  localparam int CAP_RESET    = 4000;

  // Division by five as a reciprocal multiply: x / 5 equals
  // (x * CC_RECIP) >> CC_RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] CC_RECIP       = 32'hCCCC_CCCD;
  localparam int          CC_RECIP_SHIFT = 34;

  // Divider widths.
  localparam int DIV_W  = 36;
  localparam int DIVR_W = 16;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [15:0] current;
    logic [9:0]  level;
    logic [23:0] seconds;
  } entry_t;

  // One classified item waiting in the queue.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    entry_t      entry;
    logic [15:0] charge_current;
    logic [9:0]  level_now;
    logic        target_enable;
    logic [6:0]  target_percent;
  } item_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_out_t;

endpackage

`default_nettype wire

### rtl/charge_time_to_full_estimator_unit.sv
// ----------------------------------------------------------------------------
// charge_time_to_full_estimator_unit: battery time-to-full estimator
// Loads a table of constant-voltage points and answers estimate requests.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): opcode 0 items write one table entry
// and give no result; opcode 1 items request an estimate and give one result
// on the output channel (out_valid / out_stall). Configuration (cfg_valid /
// cfg_ready): index 0 is design_capacity, index 1 is table_length; cfg_ready
// is always high. Write only while idle.
// Items pass a two-entry queue into a sequencer that handles one item at a
// time. A pass scans the table for the current match; in CV mode it scans
// again and runs at most one 36-step division, in CC mode one such division
// and a scaling by 18/5 through a multiply by 1/5. With a target enabled a
// second pass runs. Reset empties the queue and output register and restores
// design_capacity 4000 and table_length 0; table contents stay unknown until
// written. A stalled result holds and the sequencer waits on it, while the
// queue keeps taking items until full.
// ----------------------------------------------------------------------------
`default_nettype none

module charge_time_to_full_estimator_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [3:0]         entry_index,
  input  wire logic [15:0]        entry_current,
  input  wire logic [9:0]         entry_level,
  input  wire logic [23:0]        entry_seconds,
  input  wire logic [15:0]        charge_current,
  input  wire logic [9:0]         level_now,
  input  wire logic               target_enable,
  input  wire logic [6:0]         target_percent,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      eta_seconds,
  output logic                    status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic [15:0]     design_capacity;
  logic [4:0]      table_length;
  logic            head_valid;
  cttf_pkg::item_t head;
  logic            pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      design_capacity <= 16'(cttf_pkg::CAP_RESET);
      table_length    <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cttf_pkg::REG_DESIGN_CAPACITY) begin
        design_capacity <= cfg_data;
      end else if (cfg_index == cttf_pkg::REG_TABLE_LENGTH) begin
        table_length <= cfg_data[4:0];
      end
    end
  end

  cttf_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .entry_index    (entry_index),
    .entry_current  (entry_current),
    .entry_level    (entry_level),
    .entry_seconds  (entry_seconds),
    .charge_current (charge_current),
    .level_now      (level_now),
    .target_enable  (target_enable),
    .target_percent (target_percent),
    .table_length   (table_length),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop)
  );

  cttf_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .design_capacity (design_capacity),
    .table_length    (table_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .eta_seconds     (eta_seconds),
    .status          (status)
  );

endmodule

`default_nettype wire

### rtl/cttf_ram.sv
// ----------------------------------------------------------------------------
// cttf_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cttf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/cttf_front.sv
// ----------------------------------------------------------------------------
// cttf_front: input stage
// Accepts items, classifies them and keeps them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cttf_front #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  opcode,
  input  wire logic [3:0]            entry_index,
  input  wire logic [15:0]           entry_current,
  input  wire logic [9:0]            entry_level,
  input  wire logic [23:0]           entry_seconds,
  input  wire logic [15:0]           charge_current,
  input  wire logic [9:0]            level_now,
  input  wire logic                  target_enable,
  input  wire logic [6:0]            target_percent,
  input  wire logic [4:0]            table_length,
  output logic                       head_valid,
  output cttf_pkg::item_t            head,
  input  wire logic                  pop
);

  cttf_pkg::item_t slots [2];
  cttf_pkg::item_t item;
  logic            wp;
  logic            rp;
  logic [1:0]      count;
  logic            keep;
  logic            push;

  // Classify the incoming item.
  always_comb begin
    item.entry_index    = entry_index;
    item.entry.current  = entry_current;
    item.entry.level    = entry_level;
    item.entry.seconds  = entry_seconds;
    item.charge_current = charge_current;
    item.level_now      = level_now;
    item.target_enable  = target_enable;
    item.target_percent = target_percent;
    keep = 1'b1;
    if (!opcode) begin
      item.kind = cttf_pkg::KIND_WRITE;
      keep = ({3'b0, entry_index} < 7'(TABLE_DEPTH));
    end else if (table_length == 5'd0 || charge_current == 16'd0) begin
      item.kind = cttf_pkg::KIND_ERR;
    end else begin
      item.kind = cttf_pkg::KIND_EST;
    end
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall && keep;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rp];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= item;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

### rtl/cttf_div.sv
// ----------------------------------------------------------------------------
// cttf_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cttf_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cttf_pkg::DIV_W-1:0]  dividend,
  input  wire logic [cttf_pkg::DIVR_W-1:0] divisor,
  output cttf_pkg::div_out_t               status
);

  localparam int CW = $clog2(cttf_pkg::DIV_W + 1);

  logic [cttf_pkg::DIVR_W-1:0] dsr;
  logic [cttf_pkg::DIVR_W-1:0] rem;
  logic [cttf_pkg::DIV_W-1:0]  quo;
  logic [CW-1:0]               cnt;
  logic                        busy;
  logic                        done;
  logic [cttf_pkg::DIVR_W:0]   trial;
  logic                        fits;

  assign trial = {rem, quo[cttf_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // Datapath of one step.
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? cttf_pkg::DIVR_W'(trial - {1'b0, dsr})
                  : cttf_pkg::DIVR_W'(trial);
      quo <= {quo[cttf_pkg::DIV_W-2:0], fits};
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(cttf_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.quo  = quo;

endmodule

`default_nettype wire

### rtl/cttf_back.sv
// ----------------------------------------------------------------------------
// cttf_back: estimate sequencer
// Executes queued items: table writes, table scans, interpolation and the
// constant-current time, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cttf_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire cttf_pkg::item_t    head,
  output logic                    pop,
  input  wire logic [15:0]        design_capacity,
  input  wire logic [4:0]         table_length,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      eta_seconds,
  output logic                    status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_ACK  = 4'd2;
  localparam logic [3:0] S_BRD  = 4'd3;
  localparam logic [3:0] S_BCK  = 4'd4;
  localparam logic [3:0] S_CV1  = 4'd5;
  localparam logic [3:0] S_CV2  = 4'd6;
  localparam logic [3:0] S_CVW  = 4'd7;
  localparam logic [3:0] S_CC1  = 4'd8;
  localparam logic [3:0] S_CC2  = 4'd9;
  localparam logic [3:0] S_CCW  = 4'd10;
  localparam logic [3:0] S_CC3  = 4'd11;
  localparam logic [3:0] S_CC4  = 4'd12;
  localparam logic [3:0] S_SUM  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]               st;
  logic [AW-1:0]            idx;
  logic [NW-1:0]            n;
  logic [15:0]              cur;
  logic [10:0]              lvl;
  logic                     tgt_en;
  logic [10:0]              tgt_lvl;
  logic                     phase;
  logic [9:0]               ent_l;
  logic [23:0]              ent_s;
  logic [9:0]               prv_l;
  logic [23:0]              prv_s;
  logic signed [36:0]       prod;
  logic [26:0]              mulu;
  logic [63:0]              rprod;
  logic                     neg;
  logic [24:0]              cv;
  logic [31:0]              cc;
  logic [28:0]              acc;
  logic [28:0]              part;
  logic [31:0]              res;
  logic                     res_err;

  logic                     ram_we;
  logic [$bits(cttf_pkg::entry_t)-1:0] rdata;
  cttf_pkg::entry_t         rd;
  logic                     last;
  logic signed [24:0]       diff;
  logic [10:0]              gap;
  logic [36:0]              mag;
  logic                     div_start;
  logic [cttf_pkg::DIV_W-1:0]  div_a;
  logic [cttf_pkg::DIVR_W-1:0] div_b;
  cttf_pkg::div_out_t       div;
  logic                     load_out;

  // Effective table length.
  assign n = ({2'b0, table_length} > 7'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                     : NW'(table_length);

  assign pop    = (st == S_IDLE) && head_valid;
  assign ram_we = pop && (head.kind == cttf_pkg::KIND_WRITE);

  cttf_ram #(
    .WIDTH ($bits(cttf_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(head.entry_index)),
    .wdata (head.entry),
    .raddr (idx),
    .rdata (rdata)
  );

  // Entry decode and scan helpers.
  assign rd   = cttf_pkg::entry_t'(rdata);
  assign last = ((NW'(idx) + NW'(1)) == n);
  assign diff = $signed({1'b0, prv_s}) - $signed({1'b0, ent_s});
  assign gap  = {1'b0, ent_l} - lvl;
  assign mag  = prod[36] ? 37'(-prod) : prod;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (st)
      S_CV2: begin
        div_start = 1'b1;
        div_a     = mag[cttf_pkg::DIV_W-1:0];
        div_b     = cttf_pkg::DIVR_W'(ent_l - prv_l);
      end
      S_CC2: begin
        div_start = 1'b1;
        div_a     = cttf_pkg::DIV_W'(mulu);
        div_b     = cur;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  cttf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .status   (div)
  );

  // Part estimate with or without the added minute.
  assign part = 29'(cc) + 29'(cv) + (phase ? 29'd0 : 29'(cttf_pkg::MINUTE));

  assign load_out = (st == S_DONE) && (!out_valid || !out_stall);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      idx   <= '0;
      phase <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (head_valid) begin
            cur     <= head.charge_current;
            lvl     <= {1'b0, head.level_now};
            tgt_en  <= head.target_enable;
            tgt_lvl <= 11'(head.target_percent) * 11'(cttf_pkg::LEVEL_SCALE);
            phase   <= 1'b0;
            idx     <= '0;
            if (head.kind == cttf_pkg::KIND_ERR) begin
              res     <= '1;
              res_err <= 1'b1;
              st      <= S_DONE;
            end else if (head.kind == cttf_pkg::KIND_EST) begin
              res_err <= 1'b0;
              st      <= S_ARD;
            end
          end
        end
        S_ARD: begin
          st <= S_ACK;
        end
        S_ACK: begin
          // First entry whose current the charge current meets.
          if (cur >= rd.current || last) begin
            ent_l <= rd.level;
            ent_s <= rd.seconds;
            if ({1'b0, rd.level} < lvl) begin
              idx <= '0;
              st  <= S_BRD;
            end else begin
              st <= S_CC1;
            end
          end else begin
            idx <= idx + AW'(1);
            st  <= S_ARD;
          end
        end
        S_BRD: begin
          st <= S_BCK;
        end
        S_BCK: begin
          // First entry whose level reaches the charge level.
          if (lvl <= {1'b0, rd.level}) begin
            if (idx == '0 || rd.level == ent_l) begin
              cv <= {1'b0, rd.seconds};
              cc <= '0;
              st <= S_SUM;
            end else begin
              prv_l <= ent_l;
              prv_s <= ent_s;
              ent_l <= rd.level;
              ent_s <= rd.seconds;
              st    <= S_CV1;
            end
          end else if (last) begin
            cv <= {1'b0, rd.seconds};
            cc <= '0;
            st <= S_SUM;
          end else begin
            ent_l <= rd.level;
            ent_s <= rd.seconds;
            idx   <= idx + AW'(1);
            st    <= S_BRD;
          end
        end
        S_CV1: begin
          prod <= diff * $signed({1'b0, gap});
          st   <= S_CV2;
        end
        S_CV2: begin
          neg <= prod[36];
          st  <= S_CVW;
        end
        S_CVW: begin
          if (div.done) begin
            cv <= neg ? 25'({1'b0, ent_s} - div.quo[24:0])
                      : 25'({1'b0, ent_s} + div.quo[24:0]);
            cc <= '0;
            st <= S_SUM;
          end
        end
        S_CC1: begin
          mulu <= {11'b0, design_capacity} * {16'b0, gap};
          cv   <= {1'b0, ent_s};
          st   <= S_CC2;
        end
        S_CC2: begin
          st <= S_CCW;
        end
        S_CCW: begin
          if (div.done) begin
            cc <= 32'(div.quo[26:0]) * 32'(cttf_pkg::CC_SCALE_NUM);
            st <= S_CC3;
          end
        end
        S_CC3: begin
          // Divide by five through the reciprocal.
          rprod <= cc * cttf_pkg::CC_RECIP;
          st    <= S_CC4;
        end
        S_CC4: begin
          cc <= 32'(rprod[63:cttf_pkg::CC_RECIP_SHIFT]);
          st <= S_SUM;
        end
        S_SUM: begin
          if (!phase) begin
            acc <= part;
            if (tgt_en) begin
              phase <= 1'b1;
              lvl   <= tgt_lvl;
              idx   <= '0;
              st    <= S_ARD;
            end else begin
              res <= {3'b0, part};
              st  <= S_DONE;
            end
          end else begin
            res <= {3'b0, acc} - {3'b0, part};
            st  <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      eta_seconds <= $signed(res);
      status      <= res_err;
    end
  end

`ifndef SYNTHESIS
  // An error result always carries minus one.
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (eta_seconds == -32'sd1))
    else $error("error result without minus one");

  // Table scans stay inside the valid entries.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_ARD || st == S_BRD) |-> (NW'(idx) < n))
    else $error("scan index beyond table length");

  // The divider is never restarted while working.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div.busy)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

### tb/sv/charge_time_to_full_estimator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charge_time_to_full_estimator_unit_test: self-checking bench for the
// time-to-full estimator.
// Loads the constant-voltage table through write items, then walks a short
// directed table of estimates covering errors, table edges, equal levels and
// target subtraction. Random phases follow under changing capacity and table
// length, with random idling on both channels, a quiet stretch and one long
// receiver hold-off. Every result is compared against an internal estimator
// or a hand-typed expectation.
`default_nettype none

module charge_time_to_full_estimator_unit_test;

  localparam int NUM_POINTS  = 16;
  localparam int SETTLE_CYC  = 400;
  localparam int HANG_LIMIT  = 5000;
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_EST    = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_ERR    = 1'b1;

  // One input item, with an optional hand-typed expectation.
  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [15:0] ecur;
    logic [9:0]  elvl;
    logic [23:0] esec;
    logic [15:0] ccur;
    logic [9:0]  lvl;
    logic        ten;
    logic [6:0]  tpct;
    bit          typed;
    int          exp_time;
    logic        exp_status;
  } stim_t;

  typedef struct {
    logic signed [31:0] ttf;
    logic               st;
  } estimate_t;

  logic clk, rst;
  logic in_valid, in_stall, opcode;
  logic [3:0]  entry_index;
  logic [15:0] entry_current;
  logic [9:0]  entry_level;
  logic [23:0] entry_seconds;
  logic [15:0] charge_current;
  logic [9:0]  level_now;
  logic        target_enable;
  logic [6:0]  target_percent;
  logic        out_valid, out_stall;
  logic signed [31:0] eta_seconds;
  logic        status;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  charge_time_to_full_estimator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .entry_index(entry_index), .entry_current(entry_current),
    .entry_level(entry_level), .entry_seconds(entry_seconds),
    .charge_current(charge_current), .level_now(level_now),
    .target_enable(target_enable), .target_percent(target_percent),
    .out_valid(out_valid), .out_stall(out_stall),
    .eta_seconds(eta_seconds), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the table and registers.
  int pt_cur [NUM_POINTS];
  int pt_lvl [NUM_POINTS];
  int pt_sec [NUM_POINTS];
  longint capacity_mah;
  int     points_used;

  estimate_t pending_estimates[$];
  stim_t     directed_rows[$];
  stim_t     typed_q[$];
  int  mismatches, items_sent, results_seen, quiet_cycles;
  bit  no_idle;
  int  hold_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Estimate for one level: CV interpolation or CC time plus the point's time.
  function automatic longint level_estimate(longint cur, longint lvl, int n, bit add_min);
    int i, k;
    longint cv, cc, sum, hl, ll, ht, lt;
    cv = 0;
    cc = 0;
    i = 0;
    while (i < n && cur < pt_cur[i]) i++;
    if (i >= n) i = n - 1;
    if (pt_lvl[i] < lvl) begin
      k = 0;
      while (k < n && lvl > pt_lvl[k]) k++;
      if (k >= n) cv = pt_sec[n-1];
      else if (k == 0) cv = pt_sec[0];
      else begin
        hl = pt_lvl[k];
        ll = pt_lvl[k-1];
        ht = pt_sec[k];
        lt = pt_sec[k-1];
        if (hl == ll) cv = ht;
        else cv = (lt - ht) * (hl - lvl) / (hl - ll) + ht;
      end
    end else begin
      cv = pt_sec[i];
      cc = capacity_mah * (longint'(pt_lvl[i]) - lvl) / cur;
      cc = cc * 3600 / 1000;
      if (cc < 0) cc = 0;
    end
    sum = cc + cv;
    if (sum < 0) sum = 0;
    if (add_min) sum += cttf_pkg::MINUTE;
    return sum;
  endfunction

  function automatic estimate_t eta_of(int cur, int lvl, bit ten, int tpct);
    estimate_t r;
    longint total;
    int n;
    n = (points_used > NUM_POINTS) ? NUM_POINTS : points_used;
    if (n == 0 || cur == 0) begin
      r.ttf = -32'sd1;
      r.st  = ST_ERR;
      return r;
    end
    total = level_estimate(cur, lvl, n, 1'b1);
    if (ten) total -= level_estimate(cur, longint'(tpct) * cttf_pkg::LEVEL_SCALE, n, 1'b0);
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    r.ttf = total[31:0];
    r.st  = ST_OK;
    return r;
  endfunction

  // Accept items and results, predict, check, and watch for a hang.
  always @(posedge clk) begin
    estimate_t want;
    stim_t     row;
    bit        moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        row = typed_q.pop_front();
        if (opcode == OP_WRITE) begin
          pt_cur[entry_index] = int'(entry_current);
          pt_lvl[entry_index] = int'(entry_level);
          pt_sec[entry_index] = int'(entry_seconds);
        end else begin
          want = eta_of(int'(charge_current), int'(level_now), target_enable,
                        int'(target_percent));
          if (row.typed) begin
            want.ttf = row.exp_time;
            want.st  = row.exp_status;
          end
          pending_estimates.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        if (pending_estimates.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result eta_seconds=%0d status=%0d",
                   $time, eta_seconds, status);
        end else begin
          want = pending_estimates.pop_front();
          if (eta_seconds !== want.ttf) begin
            mismatches++;
            $display("%0t: eta_seconds expected %0d actual %0d",
                     $time, want.ttf, eta_seconds);
          end
          if (status !== want.st) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          end
        end
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, a quiet mode, and a counted long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 23);
  end

  task automatic send_item(stim_t s);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_q.push_back(s);
    in_valid       <= 1'b1;
    opcode         <= s.op;
    entry_index    <= s.idx;
    entry_current  <= s.ecur;
    entry_level    <= s.elvl;
    entry_seconds  <= s.esec;
    charge_current <= s.ccur;
    level_now      <= s.lvl;
    target_enable  <= s.ten;
    target_percent <= s.tpct;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drain all results, then let a trailing table write finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cttf_pkg::REG_DESIGN_CAPACITY) capacity_mah = val;
    else if (idx == cttf_pkg::REG_TABLE_LENGTH) points_used = int'(val[4:0]);
  endtask

  function automatic stim_t est_row(int cur, int lvl, bit ten, int tpct);
    stim_t s;
    s = '{default: 0};
    s.op = OP_EST;
    s.ccur = 16'(cur);
    s.lvl = 10'(lvl);
    s.ten = ten;
    s.tpct = 7'(tpct);
    return s;
  endfunction

  function automatic stim_t write_row(int idx, int cur, int lvl, int sec);
    stim_t s;
    s = '{default: 0};
    s.op = OP_WRITE;
    s.idx = 4'(idx);
    s.ecur = 16'(cur);
    s.elvl = 10'(lvl);
    s.esec = 24'(sec);
    return s;
  endfunction

  function automatic stim_t err_row(int cur);
    stim_t s;
    s = est_row(cur, 500, 1'b0, 0);
    s.typed = 1'b1;
    s.exp_time = -1;
    s.exp_status = ST_ERR;
    return s;
  endfunction

  function automatic stim_t random_item();
    stim_t s;
    if ($urandom_range(99) < 35) begin
      s = write_row($urandom_range(15), $urandom_range(65535), $urandom_range(1000),
                    $urandom_range(24'hFFFFFF));
      if ($urandom_range(3) == 0) s.esec = 24'($urandom_range(20000));
    end else begin
      s = est_row(0, $urandom_range(1000), 1'($urandom_range(1)), $urandom_range(100));
      case ($urandom_range(9))
        0:       s.ccur = 16'd0;
        1, 2, 3: s.ccur = 16'($urandom_range(1, 4000));
        default: s.ccur = 16'($urandom_range(1, 65535));
      endcase
      if ($urandom_range(9) == 0) s.tpct = 7'($urandom_range(101, 127));
    end
    s.ccur = (s.op == OP_WRITE) ? 16'($urandom_range(65535)) : s.ccur;
    return s;
  endfunction

  // Stimulus.
  initial begin
    int k;
    int caps [4];
    int lens [8];
    caps = '{0, 65535, 1, 4000};
    lens = '{1, 2, 16, 20, 31, 16, 3, 7};
    rst = 1'b1;
    in_valid = 1'b0; opcode = 1'b0; entry_index = '0; entry_current = '0;
    entry_level = '0; entry_seconds = '0; charge_current = '0; level_now = '0;
    target_enable = 1'b0; target_percent = '0;
    out_stall = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    no_idle = 1'b0; hold_cycles = 0;
    mismatches = 0; items_sent = 0; results_seen = 0; quiet_cycles = 0;
    capacity_mah = cttf_pkg::CAP_RESET;
    points_used = 0;
    foreach (pt_cur[i]) begin
      pt_cur[i] = 0;
      pt_lvl[i] = 0;
      pt_sec[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: no table after reset, then a full table load with the
    // field extremes at both ends and two entries sharing one level.
    directed_rows.push_back(err_row(1000));
    directed_rows.push_back(write_row(0, 65535, 0, 0));
    for (k = 1; k < 15; k++)
      directed_rows.push_back(write_row(k, 3000 - 200 * k, (k == 6) ? 930 : 900 + 6 * k,
                                        20000 - 1200 * k));
    directed_rows.push_back(write_row(15, 0, 1000, 24'hFFFFFF));
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    settle();
    write_reg(cttf_pkg::REG_TABLE_LENGTH, 16'd16);

    // Directed estimates: zero current, first and last point, CV saturation,
    // no lower neighbour, equal levels, interpolation and targets.
    directed_rows.delete();
    directed_rows.push_back(err_row(0));
    directed_rows.push_back(est_row(65535, 0, 1'b0, 0));
    directed_rows.push_back(est_row(1, 0, 1'b0, 0));
    directed_rows.push_back(est_row(2900, 1000, 1'b0, 0));
    directed_rows.push_back(est_row(65535, 1, 1'b0, 0));
    directed_rows.push_back(est_row(2600, 933, 1'b0, 0));
    directed_rows.push_back(est_row(2600, 925, 1'b0, 0));
    directed_rows.push_back(est_row(2000, 700, 1'b1, 0));
    directed_rows.push_back(est_row(2000, 700, 1'b1, 100));
    directed_rows.push_back(est_row(2000, 1000, 1'b1, 127));
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    settle();

    // Random phases under changing registers; one quiet, one long hold-off.
    for (int p = 0; p < 8; p++) begin
      write_reg(cttf_pkg::REG_DESIGN_CAPACITY,
                (p < 4) ? 16'(caps[p]) : 16'($urandom_range(65535)));
      write_reg(cttf_pkg::REG_TABLE_LENGTH,
                (p == 7) ? 16'($urandom_range(1, 31)) : 16'(lens[p]));
      no_idle = (p == 2);
      if (p == 4) hold_cycles = 600;
      for (k = 0; k < 50; k++) send_item(random_item());
      settle();
    end
    no_idle = 1'b0;

    $display("Sent %0d items, checked %0d estimates over 8 register settings,",
             items_sent, results_seen);
    $display("including zero and full capacity and table lengths from 1 to 31.");
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/cttf_pkg.sv
rtl/cttf_ram.sv
rtl/cttf_front.sv
rtl/cttf_div.sv
rtl/cttf_back.sv
rtl/charge_time_to_full_estimator_unit.sv
tb/sv/charge_time_to_full_estimator_unit_test.sv
